@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ hdl/uenc_pkg.sv @@
// ---------------------------------------------------------------------------
// uenc_pkg
// Shared types and constants of the UTF-8 encoder with space budget.
// ---------------------------------------------------------------------------
package uenc_pkg;

    localparam int SPACE_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int CP_BITS    = 32;
    localparam int ADDR_BITS  = 3;

    localparam logic [0:0] REG_SPACE_FOR_TEXT = 1'b0;

    localparam logic [CP_BITS-1:0] CP_MAX_1BYTE = 32'h0000_007f;
    localparam logic [CP_BITS-1:0] CP_MAX_2BYTE = 32'h0000_07ff;
    localparam logic [CP_BITS-1:0] CP_MAX_3BYTE = 32'h0000_ffff;
    localparam logic [CP_BITS-1:0] CP_MAX       = 32'h0010_ffff;

    localparam logic [7:0] LEAD2_BYTE = 8'hc0;
    localparam logic [7:0] LEAD3_BYTE = 8'he0;
    localparam logic [7:0] LEAD4_BYTE = 8'hf0;
    localparam logic [7:0] CONT_BYTE  = 8'h80;
    localparam logic [7:0] TERM_BYTE  = 8'h00;

    typedef enum logic [1:0] {
        ACT_BEGIN  = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_END    = 2'd2
    } uenc_action_t;

    // result run produced by one item; bytes[7:0] goes out first
    typedef struct packed {
        logic        has_result;
        logic [31:0] bytes;
        logic [2:0]  count;
        logic        byte_valid;
        logic        truncated;
        logic        invalid;
    } uenc_run_t;

endpackage

@@ hdl/uenc_core.sv @@
// ---------------------------------------------------------------------------
// uenc_core
// Budget and sticky flag state; turns one item into its run of result bytes.
// ---------------------------------------------------------------------------
module uenc_core import uenc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [1:0]          action,
    input  logic [CP_BITS-1:0]  code_point,
    input  logic [CFG_BITS-1:0] space_for_text,
    output uenc_run_t           run
);

    logic [SPACE_BITS-1:0] rem_space_reg, rem_space_next;
    logic                  trunc_reg, trunc_next;
    logic                  inval_reg, inval_next;

    logic [31:0] enc_bytes;
    logic [2:0]  enc_count;

    always_comb begin
        enc_bytes = '0;
        priority if (code_point <= CP_MAX_1BYTE) begin
            enc_bytes[7:0] = code_point[7:0];
            enc_count      = 3'd1;
        end else if (code_point <= CP_MAX_2BYTE) begin
            enc_bytes[7:0]  = LEAD2_BYTE | {3'b000, code_point[10:6]};
            enc_bytes[15:8] = CONT_BYTE | {2'b00, code_point[5:0]};
            enc_count       = 3'd2;
        end else if (code_point <= CP_MAX_3BYTE) begin
            enc_bytes[7:0]   = LEAD3_BYTE | {4'b0000, code_point[15:12]};
            enc_bytes[15:8]  = CONT_BYTE | {2'b00, code_point[11:6]};
            enc_bytes[23:16] = CONT_BYTE | {2'b00, code_point[5:0]};
            enc_count        = 3'd3;
        end else begin
            enc_bytes[7:0]   = LEAD4_BYTE | {5'b00000, code_point[20:18]};
            enc_bytes[15:8]  = CONT_BYTE | {2'b00, code_point[17:12]};
            enc_bytes[23:16] = CONT_BYTE | {2'b00, code_point[11:6]};
            enc_bytes[31:24] = CONT_BYTE | {2'b00, code_point[5:0]};
            enc_count        = 3'd4;
        end
    end

    always_comb begin
        rem_space_next = rem_space_reg;
        trunc_next     = trunc_reg;
        inval_next     = inval_reg;
        run            = '0;
        unique case (action)
            ACT_BEGIN: begin
                rem_space_next = SPACE_BITS'(space_for_text);
                trunc_next     = 1'b0;
                inval_next     = 1'b0;
            end
            ACT_END: begin
                run.has_result = 1'b1;
                run.bytes      = {24'h0, TERM_BYTE};
                run.count      = 3'd1;
                run.byte_valid = 1'b1;
            end
            ACT_ENCODE: begin
                run.has_result = 1'b1;
                run.count      = 3'd1;
                if (!trunc_reg) begin
                    if (code_point > CP_MAX) begin
                        inval_next = 1'b1;
                    end else if (rem_space_reg < SPACE_BITS'(enc_count)) begin
                        trunc_next = 1'b1;
                    end else begin
                        rem_space_next = rem_space_reg - SPACE_BITS'(enc_count);
                        run.bytes      = enc_bytes;
                        run.count      = enc_count;
                        run.byte_valid = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        run.truncated = trunc_next;
        run.invalid   = inval_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_space_reg <= '0;
            trunc_reg     <= 1'b0;
            inval_reg     <= 1'b0;
        end else if (load) begin
            rem_space_reg <= rem_space_next;
            trunc_reg     <= trunc_next;
            inval_reg     <= inval_next;
        end
    end

endmodule

@@ hdl/utf8_encoder_with_space_budget.sv @@
// ---------------------------------------------------------------------------
// utf8_encoder_with_space_budget
// UTF-8 encoder into a bounded byte budget, with APB budget register.
// ---------------------------------------------------------------------------
// Output: the first result of an item is registered and shows in the cycle after it is accepted.
// Throughput: one result byte per cycle from the output register while m_tready
//   is high; encode and end items give 1 to 4 results, begin and unused actions give
//   none, and a new item is taken only as the last result of the previous one is accepted.
// Reset: synchronous, active low; budget register, remaining space and flags
//   clear to zero, the output register empties.
`include "assert_macros.svh"

module utf8_encoder_with_space_budget import uenc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CP_BITS-1:0]   s_tdata,   // [31:0] code_point
    input  logic [1:0]           s_tuser,   // [1:0] action
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] out_byte
    output logic                 m_tlast,
    output logic [2:0]           m_tuser,   // [0] byte_valid, [1] truncated, [2] invalid
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [CFG_BITS-1:0] space_cfg_reg;
    logic                cfg_write;

    uenc_run_t run;
    logic      s_accept;
    logic      m_accept;
    logic      out_last;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_bytes_reg, out_bytes_next;
    logic [2:0]  out_left_reg, out_left_next;
    logic        out_bv_reg, out_bv_next;
    logic        out_trunc_reg, out_trunc_next;
    logic        out_inval_reg, out_inval_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[ADDR_BITS-1:2] == REG_SPACE_FOR_TEXT);
    assign prdata    = (paddr[ADDR_BITS-1:2] == REG_SPACE_FOR_TEXT)
                       ? {16'h0, space_cfg_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_cfg_reg <= '0;
        end else if (cfg_write) begin
            space_cfg_reg <= pwdata[CFG_BITS-1:0];
        end
    end

    assign out_last = (out_left_reg == 3'd1);
    assign m_accept = out_valid_reg && m_tready;
    assign s_tready = !out_valid_reg || (m_tready && out_last);
    assign s_accept = s_tvalid && s_tready;

    uenc_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (s_accept),
        .action         (s_tuser),
        .code_point     (s_tdata),
        .space_for_text (space_cfg_reg),
        .run            (run)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_bytes_next = out_bytes_reg;
        out_left_next  = out_left_reg;
        out_bv_next    = out_bv_reg;
        out_trunc_next = out_trunc_reg;
        out_inval_next = out_inval_reg;
        if (m_accept) begin
            out_valid_next = !out_last;
            out_bytes_next = {8'h00, out_bytes_reg[31:8]};
            out_left_next  = out_left_reg - 3'd1;
        end
        if (s_accept && run.has_result) begin
            out_valid_next = 1'b1;
            out_bytes_next = run.bytes;
            out_left_next  = run.count;
            out_bv_next    = run.byte_valid;
            out_trunc_next = run.truncated;
            out_inval_next = run.invalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_left_reg  <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            out_left_reg  <= out_left_next;
        end
        out_bytes_reg <= out_bytes_next;
        out_bv_reg    <= out_bv_next;
        out_trunc_reg <= out_trunc_next;
        out_inval_reg <= out_inval_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_bytes_reg[7:0];
    assign m_tlast  = out_last;
    assign m_tuser  = {out_inval_reg, out_trunc_reg, out_bv_reg};

    `ASSERT_NEVER(a_left_range, aclk, aresetn,
        out_valid_reg && (out_left_reg == 3'd0 || out_left_reg > 3'd4),
        "result count out of range")
    `ASSERT_PROP(a_status_single, aclk, aresetn,
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tdata == 8'h00,
        "status result must be a single zero item")
    `ASSERT_PROP(a_run_continues, aclk, aresetn,
        m_accept && !m_tlast |=> m_tvalid,
        "multi-byte run broken")

endmodule
